// ===== hdl/ppc_pkg.sv =====
// Package for the polygon plane clipper: widths, beat types, register and state codes.
`timescale 1ns / 1ps

package ppc_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int COORD_WIDTH = 32;
	localparam int CW          = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
	localparam int NCOMP       = 5;
	localparam int NRM_W       = 18;
	localparam int PD_W        = 32;
	localparam int FRAC_W      = 16;
	localparam int DIFF_W      = CW + 1;
	localparam int DOT_W       = NRM_W + CW + 2;
	localparam int SH_W        = DOT_W - FRAC_BITS;
	localparam int DIST_W      = ((SH_W > PD_W) ? SH_W : PD_W) + 1;
	localparam int DEN_W       = DIST_W + 1;
	localparam int PROD_W      = NRM_W + DIFF_W;

	localparam int P_CROSS = 0;
	localparam int P_KEEP  = 1;
	localparam int P_CLOSE = 2;
	localparam int P_EMPTY = 3;

	typedef struct packed {
		logic signed [31:0] vertex_x;
		logic signed [31:0] vertex_y;
		logic signed [31:0] vertex_z;
		logic signed [31:0] tex_s;
		logic signed [31:0] tex_t;
		logic               last_vertex;
	} vtx_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic signed [31:0] out_s;
		logic signed [31:0] out_t;
		logic               vertex_valid;
		logic               polygon_end;
	} res_t;

	typedef enum logic [1:0] {
		REG_NORMAL_X,
		REG_NORMAL_Y,
		REG_NORMAL_Z,
		REG_PLANE_DIST
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DOT,
		ST_DIST,
		ST_SEL,
		ST_ABS,
		ST_DIV,
		ST_MUL,
		ST_EMIT
	} state_t;

endpackage

// ===== hdl/polygon_plane_clip.sv =====
// Polygon plane clipper: one shared multiplier and a serial divider under a small sequencer.
// A kept vertex with no crossing passes through the dot product, distance, select and emit states.
// Each crossing adds a magnitude step, the serial divide and the multiply steps before its emit and select.
// A new vertex is taken only when the sequencer is back in idle; an output stall holds it in the emit state.
// The distance dot product runs through the shared multiplier.
// Reset clears the sequencer, polygon tracking, output valid and loads the plane registers.
`timescale 1ns / 1ps

module polygon_plane_clip (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vtx_valid,
	output logic              vtx_stall,
	input  ppc_pkg::vtx_t     vtx,
	output logic              res_valid,
	input  logic              res_stall,
	output ppc_pkg::res_t     res,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  ppc_pkg::cfg_reg_t cfg_index,
	input  logic [31:0]       cfg_data
);
	import ppc_pkg::*;

	state_t state_q, state_d;
	logic [3:0] cnt_q;
	logic [3:0] pend_q;
	logic in_poly_q, last_q, res_valid_q;
	res_t res_q;

	logic signed [NRM_W-1:0] nrm_q [3];
	logic signed [PD_W-1:0] pdist_q;

	logic signed [CW-1:0] cur_q [NCOMP];
	logic signed [CW-1:0] prev_q [NCOMP];
	logic signed [CW-1:0] first_q [NCOMP];
	logic signed [CW-1:0] rv_q [NCOMP];
	logic signed [DIST_W-1:0] d_q, prev_d_q, first_d_q;
	logic signed [DOT_W-1:0] acc_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [DEN_W-1:0] rem_q, den_q;
	logic [FRAC_W-1:0] f_q;

	logic accept, out_free, emit_load;
	logic signed [NRM_W-1:0] mul_a;
	logic signed [DIFF_W-1:0] mul_b;
	logic signed [PROD_W-1:0] mul_p;
	logic signed [DIFF_W-1:0] diff [NCOMP];
	logic signed [CW-1:0] a_sel [NCOMP];
	logic signed [CW-1:0] b_sel [NCOMP];
	logic [2:0] midx, ridx;
	logic signed [DOT_W-1:0] sh;
	logic signed [DIST_W-1:0] dist_n, fd, da, db;
	logic cr1, kp, cl, em;
	logic [DIST_W-1:0] ma, mb;
	logic [DEN_W:0] rem2;
	logic ge;
	logic signed [PROD_W-1:0] isum;
	logic [3:0] pend_next;

	function automatic logic crosses(input logic signed [DIST_W-1:0] a,
		input logic signed [DIST_W-1:0] b);
		return (a != '0) && (b != '0) && (a[DIST_W-1] != b[DIST_W-1]);
	endfunction

	function automatic logic [DIST_W-1:0] mag(input logic signed [DIST_W-1:0] x);
		logic signed [DIST_W-1:0] n;
		n = -x;
		return x[DIST_W-1] ? n : x;
	endfunction

	function automatic logic signed [CW-1:0] sat(input logic signed [PROD_W-1:0] v);
		logic same;
		same = (v[PROD_W-1:CW-1] == '0) || (v[PROD_W-1:CW-1] == '1);
		if (same)
			return v[CW-1:0];
		else if (v[PROD_W-1])
			return {1'b1, {(CW-1){1'b0}}};
		else
			return {1'b0, {(CW-1){1'b1}}};
	endfunction

	assign accept    = vtx_valid && !vtx_stall;
	assign vtx_stall = (state_q != ST_IDLE);
	assign out_free  = !res_valid_q || !res_stall;
	assign emit_load = (state_q == ST_EMIT) && out_free;
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign cfg_ready = 1'b1;
	assign pend_next = pend_q & (pend_q - 4'd1);

	assign midx = (cnt_q[2:0] < 3'(NCOMP)) ? cnt_q[2:0] : 3'd0;
	assign ridx = (cnt_q[2:0] != 3'd0) ? (cnt_q[2:0] - 3'd1) : 3'd0;

	always_comb begin
		for (int j = 0; j < NCOMP; j++) begin
			a_sel[j] = pend_q[P_CROSS] ? prev_q[j] : cur_q[j];
			b_sel[j] = pend_q[P_CROSS] ? cur_q[j] : first_q[j];
			diff[j]  = DIFF_W'(b_sel[j]) - DIFF_W'(a_sel[j]);
		end
	end

	always_comb begin
		if (state_q == ST_MUL) begin
			mul_a = {{(NRM_W-FRAC_W){1'b0}}, f_q};
			mul_b = diff[midx];
		end else begin
			unique case (cnt_q[1:0])
				2'd0: mul_a = nrm_q[0];
				2'd1: mul_a = nrm_q[1];
				2'd2: mul_a = nrm_q[2];
				default: mul_a = '0;
			endcase
			mul_b = DIFF_W'(cur_q[midx]);
		end
		mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
	end

	always_comb begin
		sh     = acc_q >>> FRAC_BITS;
		dist_n = sh[DIST_W-1:0] - DIST_W'(pdist_q);
		fd     = in_poly_q ? first_d_q : dist_n;
		cr1    = in_poly_q && crosses(prev_d_q, dist_n);
		kp     = !dist_n[DIST_W-1];
		cl     = last_q && crosses(dist_n, fd);
		em     = last_q && !(cr1 || kp || cl);
		da     = pend_q[P_CROSS] ? prev_d_q : d_q;
		db     = pend_q[P_CROSS] ? d_q : first_d_q;
		ma     = mag(da);
		mb     = mag(db);
		rem2   = {rem_q, 1'b0};
		ge     = rem2 >= {1'b0, den_q};
		isum   = PROD_W'(a_sel[ridx]) + (prod_q >>> FRAC_W);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = ST_DOT;
			ST_DOT:  if (cnt_q == 4'd3) state_d = ST_DIST;
			ST_DIST: state_d = ST_SEL;
			ST_SEL: begin
				priority if (pend_q[P_CROSS]) state_d = ST_ABS;
				else if (pend_q[P_KEEP])      state_d = ST_EMIT;
				else if (pend_q[P_CLOSE])     state_d = ST_ABS;
				else if (pend_q[P_EMPTY])     state_d = ST_EMIT;
				else                          state_d = ST_IDLE;
			end
			ST_ABS:  state_d = ST_DIV;
			ST_DIV:  if (cnt_q == 4'd15) state_d = ST_MUL;
			ST_MUL:  if (cnt_q == 4'(NCOMP)) state_d = ST_EMIT;
			ST_EMIT: if (out_free) state_d = ST_SEL;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			pend_q      <= '0;
			in_poly_q   <= 1'b0;
			res_valid_q <= 1'b0;
			nrm_q[0]    <= '0;
			nrm_q[1]    <= '0;
			nrm_q[2]    <= NRM_W'(65536);
			pdist_q     <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_NORMAL_X:   nrm_q[0] <= cfg_data[NRM_W-1:0];
					REG_NORMAL_Y:   nrm_q[1] <= cfg_data[NRM_W-1:0];
					REG_NORMAL_Z:   nrm_q[2] <= cfg_data[NRM_W-1:0];
					REG_PLANE_DIST: pdist_q  <= cfg_data[PD_W-1:0];
				endcase
			end
			if (emit_load)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (accept) cnt_q <= '0;
				ST_DOT:  cnt_q <= cnt_q + 4'd1;
				ST_DIST: pend_q <= {em, cl, kp, cr1};
				ST_SEL:  if (pend_q == '0) in_poly_q <= !last_q;
				ST_ABS:  cnt_q <= '0;
				ST_DIV:  cnt_q <= (cnt_q == 4'd15) ? 4'd0 : cnt_q + 4'd1;
				ST_MUL:  cnt_q <= cnt_q + 4'd1;
				ST_EMIT: if (out_free) pend_q <= pend_next;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cur_q[0] <= vtx.vertex_x[CW-1:0];
					cur_q[1] <= vtx.vertex_y[CW-1:0];
					cur_q[2] <= vtx.vertex_z[CW-1:0];
					cur_q[3] <= vtx.tex_s[CW-1:0];
					cur_q[4] <= vtx.tex_t[CW-1:0];
					last_q   <= vtx.last_vertex;
					acc_q    <= '0;
				end
			end
			ST_DOT: begin
				if (cnt_q < 4'd3)
					prod_q <= mul_p;
				if (cnt_q != 4'd0)
					acc_q <= acc_q + DOT_W'(prod_q);
			end
			ST_DIST: begin
				d_q <= dist_n;
				if (!in_poly_q) begin
					first_q   <= cur_q;
					first_d_q <= dist_n;
				end
			end
			ST_SEL: begin
				priority if (pend_q[P_CROSS]) begin
				end else if (pend_q[P_KEEP]) begin
					rv_q <= cur_q;
				end else if (pend_q[P_CLOSE]) begin
				end else if (pend_q[P_EMPTY]) begin
					for (int j = 0; j < NCOMP; j++)
						rv_q[j] <= '0;
				end else begin
					prev_q   <= cur_q;
					prev_d_q <= d_q;
				end
			end
			ST_ABS: begin
				rem_q <= DEN_W'(ma);
				den_q <= DEN_W'(ma) + DEN_W'(mb);
				f_q   <= '0;
			end
			ST_DIV: begin
				rem_q <= ge ? DEN_W'(rem2 - {1'b0, den_q}) : rem2[DEN_W-1:0];
				f_q   <= {f_q[FRAC_W-2:0], ge};
			end
			ST_MUL: begin
				if (cnt_q < 4'(NCOMP))
					prod_q <= mul_p;
				if (cnt_q != 4'd0)
					rv_q[ridx] <= sat(isum);
			end
			ST_EMIT: begin
				if (out_free) begin
					res_q.out_x        <= 32'(rv_q[0]);
					res_q.out_y        <= 32'(rv_q[1]);
					res_q.out_z        <= 32'(rv_q[2]);
					res_q.out_s        <= 32'(rv_q[3]);
					res_q.out_t        <= 32'(rv_q[4]);
					res_q.vertex_valid <= !pend_q[P_EMPTY];
					res_q.polygon_end  <= last_q && (pend_next == '0);
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== dv/polygon_plane_clip_test.sv =====
// Self-checking testbench for the polygon plane clipper: a predictor, random polygons, backpressure.
`timescale 1ns / 1ps

module polygon_plane_clip_test;
	import ppc_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 100;
	localparam int ONE           = 65536;

	logic      clk;
	logic      arst_n;
	logic      vtx_valid;
	logic      vtx_stall;
	vtx_t      vtx;
	logic      res_valid;
	logic      res_stall;
	res_t      res;
	logic      cfg_valid;
	logic      cfg_ready;
	cfg_reg_t  cfg_index;
	logic [31:0] cfg_data;

	longint plane_nx = 0;
	longint plane_ny = 0;
	longint plane_nz = ONE;
	longint plane_off = 0;
	vtx_t   first_vtx;
	vtx_t   prev_vtx;
	longint first_d;
	longint prev_d;
	bit     in_poly = 1'b0;

	res_t expected_vertices[$];
	int   err_count = 0;
	int   cycle_count = 0;
	bit   idle_en = 1'b1;
	int   hold_cycles = 0;

	polygon_plane_clip dut (
		.clk(clk),
		.arst_n(arst_n),
		.vtx_valid(vtx_valid),
		.vtx_stall(vtx_stall),
		.vtx(vtx),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint comp(vtx_t v, int k);
		case (k)
			0: return longint'(v.vertex_x);
			1: return longint'(v.vertex_y);
			2: return longint'(v.vertex_z);
			3: return longint'(v.tex_s);
			default: return longint'(v.tex_t);
		endcase
	endfunction

	function automatic longint plane_distance(vtx_t v);
		longint dot;
		dot = plane_nx * comp(v, 0) + plane_ny * comp(v, 1) + plane_nz * comp(v, 2);
		return (dot >>> FRAC_BITS) - plane_off;
	endfunction

	function automatic bit crosses(longint da, longint db);
		return (da != 0) && (db != 0) && ((da > 0) != (db > 0));
	endfunction

	function automatic res_t crossing(vtx_t a, longint da, vtx_t b, longint db);
		longint unsigned ma;
		longint unsigned mb;
		longint frac;
		longint hi;
		longint o[5];
		res_t r;
		ma = (da < 0) ? -da : da;
		mb = (db < 0) ? -db : db;
		frac = longint'((ma << FRAC_W) / (ma + mb));
		hi = (longint'(1) << (CW - 1)) - 1;
		for (int k = 0; k < NCOMP; k++) begin
			o[k] = comp(a, k) + ((frac * (comp(b, k) - comp(a, k))) >>> FRAC_W);
			if (o[k] > hi)
				o[k] = hi;
			else if (o[k] < -hi - 1)
				o[k] = -hi - 1;
		end
		r = '0;
		r.out_x = 32'(o[0]);
		r.out_y = 32'(o[1]);
		r.out_z = 32'(o[2]);
		r.out_s = 32'(o[3]);
		r.out_t = 32'(o[4]);
		r.vertex_valid = 1'b1;
		return r;
	endfunction

	function automatic void clip_step(vtx_t v);
		res_t step_out[$];
		res_t r;
		longint d;
		d = plane_distance(v);
		if (!in_poly) begin
			first_vtx = v;
			first_d = d;
		end else if (crosses(prev_d, d)) begin
			step_out.push_back(crossing(prev_vtx, prev_d, v, d));
		end
		if (d >= 0) begin
			r = '0;
			r.out_x = v.vertex_x;
			r.out_y = v.vertex_y;
			r.out_z = v.vertex_z;
			r.out_s = v.tex_s;
			r.out_t = v.tex_t;
			r.vertex_valid = 1'b1;
			step_out.push_back(r);
		end
		prev_vtx = v;
		prev_d = d;
		in_poly = 1'b1;
		if (v.last_vertex) begin
			if (crosses(d, first_d))
				step_out.push_back(crossing(v, d, first_vtx, first_d));
			if (step_out.size() > 0) begin
				r = step_out.pop_back();
				r.polygon_end = 1'b1;
			end else begin
				r = '0;
				r.polygon_end = 1'b1;
			end
			step_out.push_back(r);
			in_poly = 1'b0;
		end
		foreach (step_out[i])
			expected_vertices.push_back(step_out[i]);
	endfunction

	function automatic int rand_coord();
		case ($urandom_range(0, 5))
			0, 1, 2: return $urandom();
			3, 4: return int'($urandom_range(0, 1 << 19)) - (1 << 18);
			default: return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
		endcase
	endfunction

	function automatic vtx_t random_vertex(bit last);
		vtx_t v;
		v.vertex_x = rand_coord();
		v.vertex_y = rand_coord();
		v.vertex_z = rand_coord();
		v.tex_s = rand_coord();
		v.tex_t = rand_coord();
		v.last_vertex = last;
		if (plane_nx == 0 && plane_ny == 0 && (plane_nz == ONE || plane_nz == -ONE)
				&& $urandom_range(0, 4) == 0)
			v.vertex_z = 32'((plane_nz > 0) ? plane_off : -plane_off);
		return v;
	endfunction

	function automatic vtx_t axis_vertex(int z, bit last);
		vtx_t v;
		v = random_vertex(last);
		v.vertex_z = z;
		return v;
	endfunction

	function automatic logic [31:0] nrm_word(int n);
		logic [31:0] w;
		w = $urandom();
		w[17:0] = n[17:0];
		return w;
	endfunction

	task automatic send_vertex(vtx_t v);
		int gap;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			@(negedge clk);
			vtx_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		vtx_valid <= 1'b1;
		vtx <= v;
		do @(posedge clk); while (vtx_stall);
		clip_step(v);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		vtx_valid <= 1'b0;
		while (expected_vertices.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_plane_reg(cfg_reg_t idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_NORMAL_X: plane_nx = longint'($signed(val[17:0]));
			REG_NORMAL_Y: plane_ny = longint'($signed(val[17:0]));
			REG_NORMAL_Z: plane_nz = longint'($signed(val[17:0]));
			REG_PLANE_DIST: plane_off = longint'($signed(val));
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_plane();
		int off;
		if ($urandom_range(0, 2) == 0) begin
			write_plane_reg(REG_NORMAL_X, nrm_word(0));
			write_plane_reg(REG_NORMAL_Y, nrm_word(0));
			write_plane_reg(REG_NORMAL_Z, nrm_word(($urandom_range(0, 1) != 0) ? ONE : -ONE));
		end else begin
			write_plane_reg(REG_NORMAL_X, nrm_word(int'($urandom_range(0, 2 * ONE)) - ONE));
			write_plane_reg(REG_NORMAL_Y, nrm_word(int'($urandom_range(0, 2 * ONE)) - ONE));
			write_plane_reg(REG_NORMAL_Z, nrm_word(int'($urandom_range(0, 2 * ONE)) - ONE));
		end
		if ($urandom_range(0, 1) != 0)
			off = $urandom();
		else
			off = int'($urandom_range(0, 1 << 20)) - (1 << 19);
		write_plane_reg(REG_PLANE_DIST, off);
	endtask

	task automatic test_axis_plane();
		send_vertex(axis_vertex(2 * ONE, 1'b0));
		send_vertex(axis_vertex(-2 * ONE, 1'b0));
		send_vertex(axis_vertex(ONE, 1'b1));
		send_vertex(axis_vertex(-ONE, 1'b0));
		send_vertex(axis_vertex(3 * ONE, 1'b1));
		send_vertex(axis_vertex(0, 1'b0));
		send_vertex(axis_vertex(-ONE, 1'b0));
		send_vertex(axis_vertex(-ONE, 1'b1));
		send_vertex(axis_vertex(-5 * ONE, 1'b0));
		send_vertex(axis_vertex(-1, 1'b1));
		send_vertex(axis_vertex(7 * ONE, 1'b1));
		send_vertex(axis_vertex(-7 * ONE, 1'b1));
		wait_drained();
	endtask

	task automatic test_field_extremes();
		vtx_t v;
		write_plane_reg(REG_NORMAL_X, nrm_word(-ONE));
		write_plane_reg(REG_NORMAL_Y, nrm_word(ONE));
		write_plane_reg(REG_NORMAL_Z, nrm_word(ONE));
		write_plane_reg(REG_PLANE_DIST, 32'h80000000);
		v = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b0};
		send_vertex(v);
		send_vertex(~v);
		v = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 0, -1, 1'b1};
		send_vertex(v);
		wait_drained();
		write_plane_reg(REG_NORMAL_X, nrm_word(ONE));
		write_plane_reg(REG_NORMAL_Y, nrm_word(-ONE));
		write_plane_reg(REG_NORMAL_Z, nrm_word(-ONE));
		write_plane_reg(REG_PLANE_DIST, 32'h7fffffff);
		v = '{32'sh7fffffff, 32'sh80000000, 32'sh80000000, -1, 0, 1'b0};
		send_vertex(v);
		v = '{32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 1'b0};
		send_vertex(v);
		v = '{32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 1'b1};
		send_vertex(v);
		wait_drained();
	endtask

	task automatic test_drain_pause();
		random_plane();
		for (int k = 0; k < 4; k++)
			send_vertex(random_vertex(k == 3));
		wait_drained();
		for (int k = 0; k < 3; k++)
			send_vertex(random_vertex(k == 2));
		wait_drained();
	endtask

	task automatic test_backpressure();
		hold_cycles = 400;
		for (int k = 0; k < 24; k++)
			send_vertex(random_vertex(k % 4 == 3));
		wait_drained();
	endtask

	task automatic test_random_polygons(int n_items);
		int sent;
		int since_cfg;
		int len;
		bit noise;
		sent = 0;
		since_cfg = 0;
		while (sent < n_items) begin
			if (since_cfg >= 45 && !in_poly) begin
				wait_drained();
				random_plane();
				since_cfg = 0;
			end
			if (n_items - sent <= 30)
				idle_en = 1'b0;
			noise = ($urandom_range(0, 4) == 0);
			len = $urandom_range(1, 7);
			for (int k = 0; k < len; k++) begin
				send_vertex(random_vertex(noise ? bit'($urandom_range(0, 1)) : (k == len - 1)));
				sent++;
				since_cfg++;
			end
		end
	endtask

	initial begin : res_stall_drive
		int stall_left;
		stall_left = 0;
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				res_stall <= 1'b1;
				hold_cycles--;
			end else if (stall_left > 0) begin
				res_stall <= 1'b1;
				stall_left--;
			end else if (idle_en && $urandom_range(0, 4) == 0) begin
				res_stall <= 1'b1;
				stall_left = $urandom_range(1, 12) - 1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	task automatic compare_field(string name, logic signed [63:0] want, logic signed [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			err_count++;
		end
	endtask

	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_vertices.size() == 0) begin
				$display("%0t: unexpected result beat, expected none got %p", $time, res);
				err_count++;
			end else begin
				want = expected_vertices.pop_front();
				compare_field("out_x", want.out_x, res.out_x);
				compare_field("out_y", want.out_y, res.out_y);
				compare_field("out_z", want.out_z, res.out_z);
				compare_field("out_s", want.out_s, res.out_s);
				compare_field("out_t", want.out_t, res.out_t);
				compare_field("vertex_valid", want.vertex_valid, res.vertex_valid);
				compare_field("polygon_end", want.polygon_end, res.polygon_end);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("polygon_plane_clip_test NOT OK");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		vtx_valid = 1'b0;
		vtx = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_NORMAL_X;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_axis_plane();
		test_field_extremes();
		test_drain_pause();
		test_backpressure();
		test_random_polygons(130);
		wait_drained();
		if (err_count == 0)
			$display("polygon_plane_clip_test OK");
		else
			$display("polygon_plane_clip_test NOT OK");
		$finish;
	end

endmodule
